>>> sv/assert_macros.svh
// Assertion macros used by the RTL module cmss_back.
// Bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> sv/cmss_pkg.sv
// Package for the per-channel mean / std statistics block.
// Types, widths and codes shared by the front, queue and back modules.
package cmss_pkg;

  localparam int MAX_CHANNELS  = 512;
  localparam int CH_W          = $clog2(MAX_CHANNELS);
  localparam int ROOT_CHANNELS = 3;
  localparam int ROOT_IDX_W    = $clog2(ROOT_CHANNELS);
  localparam int SAMPLE_W      = 24;
  localparam int SUM_W         = 48;
  localparam int SUMSQ_W       = 64;
  localparam int CNT_W         = 24;
  localparam int DIV_W         = 96;
  localparam int DIV_I_W       = $clog2(DIV_W);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [SAMPLE_W-1:0] ONE_Q16 = 24'd65536;

  typedef enum logic [1:0] {
    OPC_ACC   = 2'd0,
    OPC_QUERY = 2'd1,
    OPC_CLEAR = 2'd2,
    OPC_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_ROOT_DELTA    = 2'd1,
    REG_STD_FLOOR     = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    JOB_ACC   = 2'd0,
    JOB_QUERY = 2'd1,
    JOB_CLEAR = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t                   kind;
    logic [CH_W-1:0]             channel;
    logic signed [SAMPLE_W-1:0]  feature;
    logic                        out_of_range;
  } job_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR    = 4'd0,
    ST_IDLE     = 4'd1,
    ST_ACC_MUL  = 4'd2,
    ST_ACC_WR   = 4'd3,
    ST_Q_LOAD   = 4'd4,
    ST_Q_MUL    = 4'd5,
    ST_Q_DIVM   = 4'd6,
    ST_Q_VSET   = 4'd7,
    ST_Q_DIVV   = 4'd8,
    ST_Q_SSET   = 4'd9,
    ST_Q_SQRT   = 4'd10,
    ST_Q_OUT    = 4'd11
  } back_state_t;

endpackage

>>> sv/cmss_front.sv
// Front end: takes input transfers, forms the root delta feature and
// classifies each item into a job for the queue. Uses cmss_pkg.
module cmss_front
  import cmss_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 opcode,
  input  logic [CH_W-1:0]            channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       first_frame,
  input  logic                       in_train,
  input  logic [CH_W:0]              channel_count,
  input  logic                       root_delta_enable,
  input  back_status_t               back_status,
  input  logic                       queue_full,
  output logic                       push,
  output job_t                       job
);

  logic [SAMPLE_W-1:0] prev_root [ROOT_CHANNELS];
  logic                accept;
  logic                is_root;
  logic                in_range;
  logic                keep;
  logic [ROOT_IDX_W-1:0] root_idx;
  logic signed [SAMPLE_W:0] delta;
  logic signed [SAMPLE_W-1:0] delta_sat;
  opcode_t             opc;

  assign opc        = opcode_t'(opcode);
  assign item_stall = queue_full | back_status.init_busy;
  assign accept     = item_valid & ~item_stall;
  assign is_root    = ({1'b0, channel} < (CH_W+1)'(ROOT_CHANNELS));
  assign root_idx   = channel[ROOT_IDX_W-1:0];
  assign in_range   = ({1'b0, channel} < channel_count);

  // Difference from the previous raw value, clamped to the sample range
  assign delta = {sample[SAMPLE_W-1], sample}
               - {prev_root[root_idx][SAMPLE_W-1], prev_root[root_idx]};
  always_comb begin
    if (delta[SAMPLE_W] != delta[SAMPLE_W-1]) begin
      delta_sat = delta[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      delta_sat = delta[SAMPLE_W-1:0];
    end
  end

  // Classify the item and build the job
  always_comb begin
    job.channel      = channel;
    job.feature      = sample;
    job.out_of_range = ~in_range;
    job.kind         = JOB_ACC;
    keep             = 1'b0;
    if (is_root && root_delta_enable) begin
      job.feature = first_frame ? '0 : delta_sat;
    end
    case (opc)
      OPC_ACC: begin
        job.kind = JOB_ACC;
        keep     = in_train & in_range;
      end
      OPC_QUERY: begin
        job.kind = JOB_QUERY;
        keep     = 1'b1;
      end
      OPC_CLEAR: begin
        job.kind = JOB_CLEAR;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept & keep;

  // Track raw root values; drop them on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROOT_CHANNELS; i++) prev_root[i] <= '0;
    end else if (accept) begin
      if (opc == OPC_CLEAR) begin
        for (int i = 0; i < ROOT_CHANNELS; i++) prev_root[i] <= '0;
      end else if (opc == OPC_ACC && keep && is_root) begin
        prev_root[root_idx] <= sample;
      end
    end
  end

endmodule

>>> sv/cmss_queue.sv
// Short job queue between the front end and the back end.
// Uses job_t from cmss_pkg.
module cmss_queue
  import cmss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> sv/cmss_back.sv
// Back end: channel stores, frame count, serial divider and square root.
// Executes queued jobs one at a time. Uses cmss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cmss_back
  import cmss_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  job_t                       q_job,
  output logic                       pop,
  output back_status_t               status,
  input  logic [CFG_DATA_W-1:0]      std_floor,
  output logic                       stat_valid,
  input  logic                       stat_stall,
  output logic [CH_W-1:0]            stat_channel,
  output logic signed [SAMPLE_W-1:0] mean,
  output logic [SAMPLE_W-1:0]        std_dev,
  output logic                       dead_channel
);

  back_state_t state, state_next;

  logic [SUM_W-1:0]   sum_mem   [MAX_CHANNELS];
  logic [SUMSQ_W-1:0] sumsq_mem [MAX_CHANNELS];
  logic [SUM_W-1:0]   sum_rd;
  logic [SUMSQ_W-1:0] sumsq_rd;
  logic [CH_W-1:0]    rd_addr;
  logic [CH_W-1:0]    wr_addr;
  logic               mem_we;
  logic [SUM_W-1:0]   sum_wdata;
  logic [SUMSQ_W-1:0] sumsq_wdata;

  job_t               job;
  logic [CH_W-1:0]    clr_addr;
  logic [CNT_W-1:0]   frame_total;

  // Accumulate path
  logic [SUM_W-1:0]   sum_upd;
  logic [SUMSQ_W-1:0] sumsq_keep;
  logic [SUM_W:0]     sum_wide;
  logic [SUMSQ_W:0]   sumsq_wide;
  logic [SAMPLE_W-1:0] fmag;

  // Shared multiplier
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod_q;

  // Query path
  logic [SUMSQ_W-1:0] sumsq_q;
  logic [SUM_W-1:0]   mag;
  logic               neg;
  logic [CNT_W-1:0]   cnt_q;
  logic [2:0]         step;
  logic [DIV_W-1:0]   acc_a, acc_b;
  logic [2*CNT_W-1:0] csq;

  // Serial divider
  logic [DIV_W-1:0]   div_n;
  logic [SUM_W-1:0]   div_r;
  logic [SUM_W-1:0]   div_d;
  logic [DIV_I_W-1:0] div_i;
  logic [SUM_W:0]     div_t, div_sub;
  logic               div_ge;

  // Square root unit
  logic [63:0]        sq_x, sq_r, sq_bit, sq_sum;
  logic [SAMPLE_W-1:0] sd24;

  // Result staging
  logic [SAMPLE_W-1:0] res_mean, res_std;
  logic               res_dead;
  logic               out_free;

  assign out_free = ~stat_valid | ~stat_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == CH_W'(MAX_CHANNELS-1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          case (q_job.kind)
            JOB_ACC:   state_next = ST_ACC_MUL;
            JOB_QUERY: state_next = ST_Q_LOAD;
            JOB_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ACC_MUL: state_next = ST_ACC_WR;
      ST_ACC_WR:  state_next = ST_IDLE;
      ST_Q_LOAD: begin
        if (job.out_of_range || frame_total == '0) state_next = ST_Q_OUT;
        else state_next = ST_Q_MUL;
      end
      ST_Q_MUL:  if (step == 3'd6) state_next = ST_Q_DIVM;
      ST_Q_DIVM: if (div_i == DIV_I_W'(DIV_W-1)) state_next = ST_Q_VSET;
      ST_Q_VSET: state_next = ST_Q_DIVV;
      ST_Q_DIVV: if (div_i == DIV_I_W'(DIV_W-1)) state_next = ST_Q_SSET;
      ST_Q_SSET: state_next = ST_Q_SQRT;
      ST_Q_SQRT: if (sq_bit == '0) state_next = ST_Q_OUT;
      ST_Q_OUT:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State machine outputs
  always_comb begin
    pop              = (state == ST_IDLE) & q_valid;
    mem_we           = (state == ST_CLEAR) | (state == ST_ACC_WR);
    status.init_busy = (state == ST_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Channel stores: one write and one registered read a cycle
  assign rd_addr     = pop ? q_job.channel : job.channel;
  assign wr_addr     = (state == ST_CLEAR) ? clr_addr : job.channel;
  assign sum_wdata   = (state == ST_CLEAR) ? '0 : sum_upd;
  assign sumsq_wide  = {1'b0, sumsq_keep} + {1'b0, prod_q};
  assign sumsq_wdata = (state == ST_CLEAR) ? '0 :
                       (sumsq_wide[SUMSQ_W] ? '1 : sumsq_wide[SUMSQ_W-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[wr_addr]   <= sum_wdata;
      sumsq_mem[wr_addr] <= sumsq_wdata;
    end
    sum_rd   <= sum_mem[rd_addr];
    sumsq_rd <= sumsq_mem[rd_addr];
  end

  // Saturating sum update
  assign sum_wide = {sum_rd[SUM_W-1], sum_rd}
                  + {{(SUM_W+1-SAMPLE_W){job.feature[SAMPLE_W-1]}}, job.feature};
  assign fmag     = job.feature[SAMPLE_W-1] ? SAMPLE_W'(-job.feature)
                                            : job.feature;

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_ACC_MUL) begin
      mul_a = {8'b0, fmag};
      mul_b = {8'b0, fmag};
    end else if (state == ST_Q_MUL) begin
      case (step)
        3'd0: begin mul_a = sumsq_q[31:0];  mul_b = {8'b0, cnt_q}; end
        3'd1: begin mul_a = sumsq_q[63:32]; mul_b = {8'b0, cnt_q}; end
        3'd2: begin mul_a = {8'b0, mag[23:0]};  mul_b = {8'b0, mag[23:0]};  end
        3'd3: begin mul_a = {8'b0, mag[23:0]};  mul_b = {8'b0, mag[47:24]}; end
        3'd4: begin mul_a = {8'b0, mag[47:24]}; mul_b = {8'b0, mag[47:24]}; end
        3'd5: begin mul_a = {8'b0, cnt_q};      mul_b = {8'b0, cnt_q};      end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // Divider and square root step logic
  assign div_t   = {div_r, div_n[DIV_W-1]};
  assign div_ge  = (div_t >= {1'b0, div_d});
  assign div_sub = div_t - {1'b0, div_d};
  assign sq_sum  = sq_r + sq_bit;
  assign sd24    = (sq_r[63:SAMPLE_W] != '0) ? '1 : sq_r[SAMPLE_W-1:0];

  // Datapath registers; the sweep address starts at zero after reset
  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
    if (rst) begin
      clr_addr    <= '0;
      frame_total <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            job      <= q_job;
            clr_addr <= '0;
          end
        end
        ST_CLEAR: begin
          clr_addr    <= clr_addr + 1'b1;
          frame_total <= '0;
        end
        ST_ACC_MUL: begin
          sumsq_keep <= sumsq_rd;
          if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_upd <= sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
          end else begin
            sum_upd <= sum_wide[SUM_W-1:0];
          end
        end
        ST_ACC_WR: begin
          if (job.channel == '0 && frame_total != '1) frame_total <= frame_total + 1'b1;
        end
        ST_Q_LOAD: begin
          sumsq_q  <= sumsq_rd;
          neg      <= sum_rd[SUM_W-1];
          mag      <= sum_rd[SUM_W-1] ? SUM_W'(-sum_rd) : sum_rd;
          cnt_q    <= frame_total;
          step     <= '0;
          res_mean <= '0;
          res_std  <= ONE_Q16;
          res_dead <= 1'b1;
        end
        ST_Q_MUL: begin
          step <= step + 1'b1;
          // Fold in the product issued on the previous step
          case (step)
            3'd1: acc_a <= {32'b0, prod_q};
            3'd2: acc_a <= acc_a + ({32'b0, prod_q} << 32);
            3'd3: acc_b <= {32'b0, prod_q};
            3'd4: acc_b <= acc_b + ({32'b0, prod_q} << 25);
            3'd5: acc_b <= acc_b + ({32'b0, prod_q} << 48);
            3'd6: begin
              csq   <= prod_q[2*CNT_W-1:0];
              div_n <= {47'b0, {1'b0, mag} + {26'b0, cnt_q[CNT_W-1:1]}};
              div_r <= '0;
              div_d <= {24'b0, cnt_q};
              div_i <= '0;
            end
            default: ;
          endcase
        end
        ST_Q_DIVM, ST_Q_DIVV: begin
          div_n <= {div_n[DIV_W-2:0], div_ge};
          div_r <= div_ge ? div_sub[SUM_W-1:0] : div_t[SUM_W-1:0];
          div_i <= div_i + 1'b1;
        end
        ST_Q_VSET: begin
          // Round and clamp the mean, then start the variance divide
          if (neg) begin
            res_mean <= (div_n > DIV_W'(24'h800000)) ? 24'h800000
                                                      : SAMPLE_W'(-div_n[SAMPLE_W-1:0]);
          end else begin
            res_mean <= (div_n > DIV_W'(24'h7FFFFF)) ? 24'h7FFFFF
                                                      : div_n[SAMPLE_W-1:0];
          end
          div_n <= (acc_a >= acc_b) ? acc_a - acc_b : '0;
          div_r <= '0;
          div_d <= csq;
          div_i <= '0;
        end
        ST_Q_SSET: begin
          sq_x   <= (div_n[DIV_W-1:64] != '0) ? '1 : div_n[63:0];
          sq_r   <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
        end
        ST_Q_SQRT: begin
          if (sq_bit != '0) begin
            if (sq_x >= sq_sum) begin
              sq_x <= sq_x - sq_sum;
              sq_r <= (sq_r >> 1) + sq_bit;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else begin
            res_dead <= (sd24 < {8'b0, std_floor});
            res_std  <= (sd24 < {8'b0, std_floor}) ? ONE_Q16 : sd24;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stat_valid <= 1'b0;
    end else if (state == ST_Q_OUT && out_free) begin
      stat_valid <= 1'b1;
    end else if (~stat_stall) begin
      stat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_Q_OUT && out_free) begin
      stat_channel <= job.channel;
      mean         <= res_mean;
      std_dev      <= res_std;
      dead_channel <= res_dead;
    end
  end

  `ASSERT_PROP(a_dead_is_one, clk, rst, (stat_valid && dead_channel) |-> (std_dev == ONE_Q16))
  `ASSERT_PROP(a_live_above_floor, clk, rst, (stat_valid && !dead_channel) |-> (std_dev >= {8'b0, std_floor}))
  `ASSERT_PROP(a_sweep_ends, clk, rst, (state == ST_CLEAR && clr_addr == CH_W'(MAX_CHANNELS-1)) |=> (state == ST_IDLE))
  `ASSERT_NEVER(a_div_overrun, clk, rst, (state == ST_Q_DIVM || state == ST_Q_DIVV) && (div_i > DIV_I_W'(DIV_W-1)))

endmodule

>>> sv/channel_mean_std_stats.sv
// Per-channel mean and standard deviation accumulator. In the back end a
// sample goes through store read, square and saturating write-back on the sum
// and sum-of-squares memories, each with one read and one write port; a query
// runs two 96-step passes of the serial divider and 32 steps of the square
// root unit; a clear sweeps all 512 channel entries, one a cycle. After reset
// the same clearing pass runs and item input stays stalled until it ends;
// configuration writes are taken throughout. A two-entry job queue lets the
// input side take items while the back end is busy, and the result register
// lets the back end go on while a result waits.
module channel_mean_std_stats
  import cmss_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 opcode,
  input  logic [CH_W-1:0]            channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       first_frame,
  input  logic                       in_train,
  output logic                       stat_valid,
  input  logic                       stat_stall,
  output logic [CH_W-1:0]            stat_channel,
  output logic signed [SAMPLE_W-1:0] mean,
  output logic [SAMPLE_W-1:0]        std_dev,
  output logic                       dead_channel
);

  logic [CH_W:0]           channel_count;
  logic                    root_delta_enable;
  logic [CFG_DATA_W-1:0]   std_floor;
  logic                    push, queue_full, pop, q_valid;
  job_t                    push_job, q_job;
  back_status_t            back_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count     <= (CH_W+1)'(MAX_CHANNELS);
      root_delta_enable <= 1'b0;
      std_floor         <= 16'd7;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_CHANNEL_COUNT: channel_count     <= cfg_data[CH_W:0];
        REG_ROOT_DELTA:    root_delta_enable <= cfg_data[0];
        REG_STD_FLOOR:     std_floor         <= cfg_data;
        default: ;
      endcase
    end
  end

  cmss_front u_front (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .opcode            (opcode),
    .channel           (channel),
    .sample            (sample),
    .first_frame       (first_frame),
    .in_train          (in_train),
    .channel_count     (channel_count),
    .root_delta_enable (root_delta_enable),
    .back_status       (back_status),
    .queue_full        (queue_full),
    .push              (push),
    .job               (push_job)
  );

  cmss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_job)
  );

  cmss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .pop          (pop),
    .status       (back_status),
    .std_floor    (std_floor),
    .stat_valid   (stat_valid),
    .stat_stall   (stat_stall),
    .stat_channel (stat_channel),
    .mean         (mean),
    .std_dev      (std_dev),
    .dead_channel (dead_channel)
  );

endmodule

>>> tb/sv/tb_cmss_checker.sv
// Checker for channel_mean_std_stats: watches the item, result and register ports.
// Keeps its own copy of the statistics stores, works out each query's result
// and compares it with what the block returns. Depends on cmss_pkg.
`timescale 1ns / 100ps

module tb_cmss_checker
  import cmss_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  logic [1:0]                 opcode,
  input  logic [CH_W-1:0]            channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       first_frame,
  input  logic                       in_train,
  input  logic                       stat_valid,
  input  logic                       stat_stall,
  input  logic [CH_W-1:0]            stat_channel,
  input  logic signed [SAMPLE_W-1:0] mean,
  input  logic [SAMPLE_W-1:0]        std_dev,
  input  logic                       dead_channel,
  output int                         fail_count,
  output int                         pending_count
);

  typedef struct {
    logic [CH_W-1:0]     chan;
    logic [SAMPLE_W-1:0] mean_q16;
    logic [SAMPLE_W-1:0] std_q16;
    logic                dead;
  } stat_result_t;

  // Model copy of the stores and registers
  logic signed [SUM_W-1:0]    sum_mem   [MAX_CHANNELS];
  logic [SUMSQ_W-1:0]         sumsq_mem [MAX_CHANNELS];
  logic [CNT_W-1:0]           frames;
  logic signed [SAMPLE_W-1:0] last_root [ROOT_CHANNELS];
  logic [9:0]                 active_channels;
  logic                       delta_mode;
  logic [15:0]                floor_q16;

  stat_result_t expected_stats[$];

  function automatic void wipe_stores();
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      sum_mem[i]   = '0;
      sumsq_mem[i] = '0;
    end
    for (int i = 0; i < ROOT_CHANNELS; i++) last_root[i] = '0;
    frames = '0;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Fold one training sample into its channel
  function automatic void add_sample(logic [CH_W-1:0] ch, logic signed [23:0] v, logic ff);
    logic signed [23:0] feat;
    logic signed [24:0] diff;
    logic signed [48:0] s;
    logic signed [63:0] prod;
    logic [64:0]        sq_total;
    feat = v;
    if (ch < ROOT_CHANNELS) begin
      if (delta_mode) begin
        if (ff) begin
          feat = '0;
        end else begin
          diff = v - last_root[ch];
          if (diff > 25'sd8388607) diff = 25'sd8388607;
          if (diff < -25'sd8388608) diff = -25'sd8388608;
          feat = diff[23:0];
        end
      end
      last_root[ch] = v;
    end
    s = sum_mem[ch] + feat;
    if (s > 49'sh7FFF_FFFF_FFFF) s = 49'sh7FFF_FFFF_FFFF;
    if (s < -49'sh8000_0000_0000) s = -49'sh8000_0000_0000;
    sum_mem[ch] = s[47:0];
    prod = feat * feat;
    sq_total = {1'b0, sumsq_mem[ch]} + {1'b0, prod};
    sumsq_mem[ch] = sq_total[64] ? '1 : sq_total[63:0];
    if (ch == 0 && frames != '1) frames = frames + 1'b1;
  endfunction

  function automatic stat_result_t channel_stats(logic [CH_W-1:0] ch);
    stat_result_t r;
    logic [63:0]  mag;
    logic [63:0]  q;
    logic [127:0] num;
    logic [127:0] msq;
    logic [63:0]  var_q32;
    logic [63:0]  sd;
    r.chan = ch;
    if (ch >= active_channels || frames == 0) begin
      r.mean_q16 = '0;
      r.std_q16  = ONE_Q16;
      r.dead     = 1'b1;
      return r;
    end
    mag = sum_mem[ch][47] ? 64'(-sum_mem[ch]) : 64'(sum_mem[ch]);
    q = (mag + 64'(frames / 2)) / 64'(frames);
    if (sum_mem[ch][47]) r.mean_q16 = (q > 64'd8388608) ? 24'h800000 : 24'(-q);
    else                 r.mean_q16 = (q > 64'd8388607) ? 24'h7FFFFF : q[23:0];
    num = 128'(sumsq_mem[ch]) * 128'(frames);
    msq = 128'(mag) * 128'(mag);
    num = (msq > num) ? '0 : num - msq;
    num = num / 128'(frames);
    num = num / 128'(frames);
    var_q32 = (num[127:64] != 0) ? '1 : num[63:0];
    sd = int_sqrt(var_q32);
    if (sd > 64'hFFFFFF) sd = 64'hFFFFFF;
    r.dead    = sd < 64'(floor_q16);
    r.std_q16 = r.dead ? ONE_Q16 : sd[23:0];
    return r;
  endfunction

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    active_channels = 10'd512;
    delta_mode      = 1'b0;
    floor_q16       = 16'd7;
    wipe_stores();
  end

  always @(posedge clk) begin
    stat_result_t want;
    if (!rst) begin
      // Compare a result transfer with the oldest expectation
      if (stat_valid && !stat_stall) begin
        if (expected_stats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result for channel %0d", $realtime, stat_channel);
        end else begin
          want = expected_stats.pop_front();
          if (stat_channel !== want.chan || mean !== want.mean_q16 ||
              std_dev !== want.std_q16 || dead_channel !== want.dead) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: channel exp %0d got %0d, mean exp %h got %h, std exp %h got %h, dead exp %b got %b",
                       $realtime, want.chan, stat_channel, want.mean_q16, mean,
                       want.std_q16, std_dev, want.dead, dead_channel);
          end
        end
      end
      // Track register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: active_channels = cfg_data[9:0];
          REG_ROOT_DELTA:    delta_mode      = cfg_data[0];
          REG_STD_FLOOR:     floor_q16       = cfg_data[15:0];
          default: ;
        endcase
      end
      // Advance the model on each item transfer
      if (item_valid && !item_stall) begin
        case (opcode)
          OPC_ACC:
            if (in_train && channel < active_channels) add_sample(channel, sample, first_frame);
          OPC_QUERY: expected_stats.push_back(channel_stats(channel));
          OPC_CLEAR: wipe_stores();
          default: ;
        endcase
      end
      pending_count = expected_stats.size();
    end
  end

endmodule

>>> tb/sv/tb_channel_mean_std_stats.sv
// Top of the channel_mean_std_stats testbench: clock, reset, register writes,
// item stimulus and result stalls. Checking is done by tb_cmss_checker.
// Depends on cmss_pkg, channel_mean_std_stats and tb_cmss_checker.
`timescale 1ns / 100ps

module tb_channel_mean_std_stats;
  import cmss_pkg::*;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       item_valid;
  logic                       item_stall;
  logic [1:0]                 opcode;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       first_frame;
  logic                       in_train;
  logic                       stat_valid;
  logic                       stat_stall;
  logic [CH_W-1:0]            stat_channel;
  logic signed [SAMPLE_W-1:0] mean;
  logic [SAMPLE_W-1:0]        std_dev;
  logic                       dead_channel;
  int                         fail_count;
  int                         pending_count;
  logic                       gaps_on;
  int                         stall_left;
  int                         sent;

  channel_mean_std_stats uut (.*);

  tb_cmss_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Result-side stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      stat_stall = 1'b1;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 3);
      stat_stall = 1'b1;
    end else begin
      stat_stall = 1'b0;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Drive one item and hold it until the transfer; called at a falling edge
  task automatic send_item(logic [1:0] op, logic [8:0] ch, logic [23:0] value,
                           logic ff, logic tr);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    opcode      = op;
    channel     = ch;
    sample      = value;
    first_frame = ff;
    in_train    = tr;
    item_valid  = 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    sent++;
  endtask

  // Drop valid and let the block drain, including a trailing clear
  task automatic drain();
    item_valid = 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [23:0] pick_value(int style, logic [23:0] base);
    case (style)
      0:       return 24'($urandom);
      1:       return base + 24'($urandom_range(0, 2000)) - 24'd1000;
      default: return base;
    endcase
  endfunction

  // Clips of whole frames with random content, queries between frames, some noise
  task automatic run_clips(int n_items);
    int          width;
    int          style;
    int          frame;
    logic [23:0] base;
    width = (checker_i.active_channels < 6) ? int'(checker_i.active_channels) : 6;
    while (sent < n_items) begin
      style = $urandom_range(0, 2);
      base  = 24'($urandom);
      for (frame = 0; frame < $urandom_range(1, 5); frame++) begin
        for (int c = 0; c < width; c++)
          send_item(OPC_ACC, 9'(c), pick_value(style, base), frame == 0,
                    $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 2) == 0)
          send_item(OPC_QUERY, ($urandom_range(0, 4) == 0) ? 9'($urandom) :
                    9'($urandom_range(0, width - 1)), 24'($urandom), 1'($urandom),
                    1'($urandom));
        if ($urandom_range(0, 5) == 0)
          send_item(2'($urandom), 9'($urandom), 24'($urandom), 1'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 15) == 0)
        send_item(OPC_CLEAR, 9'($urandom), 24'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = REG_CHANNEL_COUNT;
    cfg_data    = '0;
    item_valid  = 1'b0;
    opcode      = OPC_NOP;
    channel     = '0;
    sample      = '0;
    first_frame = 1'b0;
    in_train    = 1'b0;
    stat_stall  = 1'b0;
    stall_left  = 0;
    gaps_on     = 1'b1;
    sent        = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty counts, sample extremes, delta saturation, ignored items
    write_reg(REG_CHANNEL_COUNT, 16'd512);
    write_reg(REG_ROOT_DELTA, 16'd1);
    write_reg(REG_STD_FLOOR, 16'd7);
    send_item(OPC_QUERY, 9'd0, 24'd0, 1'b0, 1'b1);
    send_item(OPC_ACC, 9'd0, 24'h7FFFFF, 1'b1, 1'b1);
    send_item(OPC_ACC, 9'd0, 24'h800000, 1'b0, 1'b1);
    send_item(OPC_ACC, 9'd1, 24'h123456, 1'b1, 1'b1);
    send_item(OPC_ACC, 9'd1, 24'hFEDCBA, 1'b0, 1'b1);
    send_item(OPC_ACC, 9'd2, 24'h000100, 1'b0, 1'b1);
    send_item(OPC_ACC, 9'd511, 24'h7FFFFF, 1'b0, 1'b1);
    send_item(OPC_ACC, 9'd511, 24'h800000, 1'b1, 1'b1);
    send_item(OPC_ACC, 9'd3, 24'h400000, 1'b0, 1'b0);
    send_item(OPC_ACC, 9'd4, 24'h000005, 1'b0, 1'b1);
    send_item(OPC_NOP, 9'd5, 24'h7FFFFF, 1'b1, 1'b1);
    send_item(OPC_QUERY, 9'd0, 24'd0, 1'b0, 1'b0);
    send_item(OPC_QUERY, 9'd1, 24'd0, 1'b0, 1'b0);
    send_item(OPC_QUERY, 9'd2, 24'd0, 1'b0, 1'b0);
    send_item(OPC_QUERY, 9'd3, 24'd0, 1'b0, 1'b0);
    send_item(OPC_QUERY, 9'd4, 24'd0, 1'b0, 1'b0);
    send_item(OPC_QUERY, 9'd511, 24'd0, 1'b0, 1'b0);
    send_item(OPC_CLEAR, 9'd0, 24'd0, 1'b0, 1'b0);
    send_item(OPC_QUERY, 9'd0, 24'd0, 1'b0, 1'b0);
    send_item(OPC_ACC, 9'd0, 24'h000001, 1'b0, 1'b1);
    send_item(OPC_QUERY, 9'd0, 24'd0, 1'b0, 1'b0);
    drain();

    // Random phases through a spread of register settings
    write_reg(REG_ROOT_DELTA, 16'd0);
    run_clips(90);
    drain();
    write_reg(REG_CHANNEL_COUNT, 16'd1);
    write_reg(REG_ROOT_DELTA, 16'd1);
    write_reg(REG_STD_FLOOR, 16'd0);
    run_clips(150);
    drain();
    write_reg(REG_CHANNEL_COUNT, 16'd6);
    write_reg(REG_STD_FLOOR, 16'd65535);
    run_clips(210);
    drain();
    write_reg(REG_CHANNEL_COUNT, 16'd4);
    write_reg(REG_ROOT_DELTA, 16'd0);
    write_reg(REG_STD_FLOOR, 16'($urandom));
    run_clips(270);
    drain();
    write_reg(REG_CHANNEL_COUNT, 16'd3);
    write_reg(REG_ROOT_DELTA, 16'd1);
    write_reg(REG_STD_FLOOR, 16'd300);
    run_clips(340);
    drain();

    // Final stretch without idling
    gaps_on = 1'b0;
    write_reg(REG_CHANNEL_COUNT, 16'($urandom_range(1, 512)));
    write_reg(REG_ROOT_DELTA, 16'($urandom_range(0, 1)));
    write_reg(REG_STD_FLOOR, 16'($urandom_range(0, 400)));
    run_clips(420);
    drain();

    if (fail_count == 0) begin
      $display("channel_mean_std_stats verification clean");
    end else begin
      $display("channel_mean_std_stats verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10ms;
    $display("channel_mean_std_stats verification failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/cmss_pkg.sv
sv/cmss_front.sv
sv/cmss_queue.sv
sv/cmss_back.sv
sv/channel_mean_std_stats.sv
tb/sv/tb_cmss_checker.sv
tb/sv/tb_channel_mean_std_stats.sv
